/* hdl/pmnf_pkg.sv */
// Shared types, constants and helpers of the picture mask number formatter.
package pmnf_pkg;

  localparam int unsigned CHARS_MAX  = 16;
  localparam int unsigned BCD_DIGITS = 20;
  localparam int unsigned VAL_W      = 64;
  localparam int unsigned LEN_W      = 5;

  typedef enum logic [1:0] {
    REG_MASK_LOW  = 2'd0,
    REG_MASK_HIGH = 2'd1,
    REG_MASK_LEN  = 2'd2,
    REG_KIND      = 2'd3
  } cfg_reg_e;

  localparam logic [7:0] CH_HASH  = 8'h23;
  localparam logic [7:0] CH_ZERO  = 8'h30;
  localparam logic [7:0] CH_MINUS = 8'h2D;
  localparam logic [7:0] CH_PLUS  = 8'h2B;
  localparam logic [7:0] CH_DOT   = 8'h2E;
  localparam logic [7:0] CH_COMMA = 8'h2C;
  localparam logic [7:0] CH_SPACE = 8'h20;

  typedef logic [CHARS_MAX-1:0][7:0] chars_t;
  typedef logic [BCD_DIGITS-1:0][3:0] bcd_t;

  // Magnitude on its way through the scaling cells.
  typedef struct packed {
    logic [VAL_W-1:0] mag;
    logic             neg;
  } scl_t;

  // Binary remainder and BCD accumulator on their way through the converter.
  typedef struct packed {
    logic [VAL_W-1:0] bin;
    bcd_t             bcd;
    logic             neg;
  } dab_t;

  function automatic logic is_digit_pos(input logic [7:0] c);
    return (c == CH_HASH) || (c == CH_ZERO);
  endfunction

  function automatic logic is_sign_pos(input logic [7:0] c);
    return (c == CH_MINUS) || (c == CH_PLUS);
  endfunction

endpackage

/* hdl/pmnf_scale_cell.sv */
// One decimal scaling cell: multiply the magnitude by ten when enabled.
module pmnf_scale_cell import pmnf_pkg::*; (
  input  logic clk_i,
  input  logic rst_ni,
  input  logic en_i,
  input  logic in_valid_i,
  input  scl_t in_data_i,
  output logic in_ready_o,
  output logic out_valid_o,
  output scl_t out_data_o,
  input  logic out_ready_i
);

  logic valid_q;
  scl_t data_q, data_d;

  assign in_ready_o = !valid_q || out_ready_i;

  always_comb begin
    data_d = in_data_i;
    if (en_i) begin
      data_d.mag = (in_data_i.mag << 3) + (in_data_i.mag << 1);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (in_ready_o) begin
      valid_q <= in_valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_ready_o && in_valid_i) begin
      data_q <= data_d;
    end
  end

  assign out_valid_o = valid_q;
  assign out_data_o  = data_q;

endmodule

/* hdl/pmnf_dabble_cell.sv */
// One binary to BCD cell: correct every digit, then shift in the next binary bit.
module pmnf_dabble_cell import pmnf_pkg::*; (
  input  logic clk_i,
  input  logic rst_ni,
  input  logic in_valid_i,
  input  dab_t in_data_i,
  output logic in_ready_o,
  output logic out_valid_o,
  output dab_t out_data_o,
  input  logic out_ready_i
);

  logic valid_q;
  dab_t data_q, data_d;
  bcd_t corr;

  assign in_ready_o = !valid_q || out_ready_i;

  always_comb begin
    for (int j = 0; j < BCD_DIGITS; j++) begin
      corr[j] = (in_data_i.bcd[j] >= 4'd5) ? in_data_i.bcd[j] + 4'd3 : in_data_i.bcd[j];
    end
    data_d.neg = in_data_i.neg;
    // Drop the top bit: twenty digits always hold a 64-bit magnitude.
    data_d.bcd = (4*BCD_DIGITS)'({corr, in_data_i.bin[VAL_W-1]});
    data_d.bin = in_data_i.bin << 1;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (in_ready_o) begin
      valid_q <= in_valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_ready_o && in_valid_i) begin
      data_q <= data_d;
    end
  end

  assign out_valid_o = valid_q;
  assign out_data_o  = data_q;

endmodule

/* hdl/pmnf_place.sv */
// Output stage: lay the BCD digits and signs into the mask and hold the result.
module pmnf_place import pmnf_pkg::*; (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  chars_t           mask_i,
  input  logic [LEN_W-1:0] len_i,
  input  logic [LEN_W-1:0] dec_i,
  input  logic             in_valid_i,
  input  dab_t             in_data_i,
  output logic             in_ready_o,
  output logic             out_valid_o,
  output logic [VAL_W-1:0] text_low_o,
  output logic [VAL_W-1:0] text_high_o,
  output logic [LEN_W-1:0] text_length_o,
  input  logic             out_stall_i
);

  logic             valid_q;
  chars_t           text_q, text_d;
  logic [LEN_W-1:0] len_q;
  logic [BCD_DIGITS:0] nz_from;

  assign in_ready_o = !valid_q || !out_stall_i;

  always_comb begin
    logic [LEN_W-1:0] k;
    logic [7:0]       c;
    logic [3:0]       dig;
    nz_from[BCD_DIGITS] = 1'b0;
    for (int j = BCD_DIGITS - 1; j >= 0; j--) begin
      nz_from[j] = nz_from[j+1] | (in_data_i.bcd[j] != 4'd0);
    end
    for (int p = 0; p < CHARS_MAX; p++) begin
      c = mask_i[p];
      k = '0;
      for (int q = 0; q < CHARS_MAX; q++) begin
        if (q > p && LEN_W'(q) < len_i && is_digit_pos(mask_i[q])) begin
          k = k + LEN_W'(1);
        end
      end
      dig = in_data_i.bcd[k];
      if (LEN_W'(p) >= len_i) begin
        text_d[p] = 8'h00;
      end else if (is_digit_pos(c)) begin
        if (k <= dec_i || nz_from[k]) begin
          text_d[p] = CH_ZERO + {4'd0, dig};
        end else begin
          text_d[p] = (c == CH_ZERO) ? CH_ZERO : CH_SPACE;
        end
      end else if (is_sign_pos(c)) begin
        text_d[p] = in_data_i.neg ? CH_MINUS : ((c == CH_PLUS) ? CH_PLUS : CH_SPACE);
      end else begin
        text_d[p] = c;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (in_ready_o) begin
      valid_q <= in_valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_ready_o && in_valid_i) begin
      text_q <= text_d;
      len_q  <= len_i;
    end
  end

  assign out_valid_o   = valid_q;
  assign text_low_o    = text_q[7:0];
  assign text_high_o   = text_q[15:8];
  assign text_length_o = len_q;

endmodule

/* hdl/picture_mask_number_formatter.sv */
// Top level of the picture mask number formatter: config, magnitude stage and cell chains.
//
//   channel | direction | handshake              | payload
//   --------+-----------+------------------------+-------------------------------------
//   in      | to block  | in_valid_i, in_stall_o | value_bits_i
//   out     | from block| out_valid_o,out_stall_i| text_low_o, text_high_o, text_length_o
//   cfg     | to block  | cfg_we_i               | cfg_index_i, cfg_data_i
//
// The chain is one magnitude stage, one x10 scaling cell per possible decimal place, one
// binary to BCD cell per value bit and the output register. A new transaction enters
// every cycle while in_stall_o is low.
// Every stage holds its own valid bit and advances when the next stage is empty or
// moving, so a stalled result fills the chain bubble by bubble before in_stall_o rises.
// Reset clears the valid bits and the configuration registers; payload is not reset.
module picture_mask_number_formatter import pmnf_pkg::*; #(
  parameter int unsigned MASK_CHARS = 16
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             cfg_we_i,
  input  logic [1:0]       cfg_index_i,
  input  logic [VAL_W-1:0] cfg_data_i,
  input  logic             in_valid_i,
  output logic             in_stall_o,
  input  logic [VAL_W-1:0] value_bits_i,
  output logic             out_valid_o,
  input  logic             out_stall_i,
  output logic [VAL_W-1:0] text_low_o,
  output logic [VAL_W-1:0] text_high_o,
  output logic [LEN_W-1:0] text_length_o
);

  // One scaling cell per decimal place that the mask can hold; keep at least one.
  localparam int unsigned SCALE_CELLS = (MASK_CHARS > 1) ? MASK_CHARS - 1 : 1;

  // Configuration registers.
  logic [VAL_W-1:0] mask_low_q, mask_high_q;
  logic [LEN_W-1:0] mask_len_q;
  logic [2:0]       kind_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mask_low_q  <= '0;
      mask_high_q <= '0;
      mask_len_q  <= '0;
      kind_q      <= '0;
    end else if (cfg_we_i) begin
      case (cfg_reg_e'(cfg_index_i))
        REG_MASK_LOW:  mask_low_q  <= cfg_data_i;
        REG_MASK_HIGH: mask_high_q <= cfg_data_i;
        REG_MASK_LEN:  mask_len_q  <= cfg_data_i[LEN_W-1:0];
        REG_KIND:      kind_q      <= cfg_data_i[2:0];
        default:       ;
      endcase
    end
  end

  // Mask decode; the user must keep it static while transactions are in flight, the block does not enforce this.
  chars_t           mask;
  logic [LEN_W-1:0] len, dec;

  assign mask = {mask_high_q, mask_low_q};
  assign len  = (mask_len_q > LEN_W'(MASK_CHARS)) ? LEN_W'(MASK_CHARS) : mask_len_q;

  always_comb begin
    logic seen;
    seen = 1'b0;
    dec  = '0;
    for (int i = 0; i < CHARS_MAX; i++) begin
      if (LEN_W'(i) < len) begin
        if (mask[i] == CH_DOT || mask[i] == CH_COMMA) begin
          seen = 1'b1;
        end else if (seen && is_digit_pos(mask[i])) begin
          dec = dec + LEN_W'(1);
        end
      end
    end
  end

  // Magnitude stage: select the kind's width, strip the sign.
  logic             mag_v_q, mag_ready;
  scl_t             mag_q, mag_d;
  logic [VAL_W-1:0] wmask, vraw, sbit;

  always_comb begin
    case (kind_q[1:0])
      2'd0:    wmask = VAL_W'(64'h0000_0000_0000_00FF);
      2'd1:    wmask = VAL_W'(64'h0000_0000_0000_FFFF);
      2'd2:    wmask = VAL_W'(64'h0000_0000_FFFF_FFFF);
      default: wmask = '1;
    endcase
    sbit      = wmask & ~(wmask >> 1);
    vraw      = value_bits_i & wmask;
    mag_d.neg = kind_q[2] && ((vraw & sbit) != '0);
    mag_d.mag = mag_d.neg ? ((~vraw + VAL_W'(1)) & wmask) : vraw;
  end

  logic scl_v   [SCALE_CELLS+1];
  logic scl_rdy [SCALE_CELLS+1];
  scl_t scl_dat [SCALE_CELLS+1];

  assign mag_ready  = !mag_v_q || scl_rdy[0];
  assign in_stall_o = !mag_ready;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mag_v_q <= 1'b0;
    end else if (mag_ready) begin
      mag_v_q <= in_valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (mag_ready && in_valid_i) begin
      mag_q <= mag_d;
    end
  end

  assign scl_v[0]   = mag_v_q;
  assign scl_dat[0] = mag_q;

  // Scaling chain: cell k multiplies by ten when k is below the decimals count.
  for (genvar k = 0; k < SCALE_CELLS; k++) begin : g_scale
    pmnf_scale_cell u_cell (
      .clk_i       (clk_i),
      .rst_ni      (rst_ni),
      .en_i        (LEN_W'(k) < dec),
      .in_valid_i  (scl_v[k]),
      .in_data_i   (scl_dat[k]),
      .in_ready_o  (scl_rdy[k]),
      .out_valid_o (scl_v[k+1]),
      .out_data_o  (scl_dat[k+1]),
      .out_ready_i (scl_rdy[k+1])
    );
  end

  // Binary to BCD chain, one value bit per cell, most significant first.
  logic dab_v   [VAL_W+1];
  logic dab_rdy [VAL_W+1];
  dab_t dab_dat [VAL_W+1];

  assign dab_v[0]                = scl_v[SCALE_CELLS];
  assign dab_dat[0].bin          = scl_dat[SCALE_CELLS].mag;
  assign dab_dat[0].bcd          = '0;
  assign dab_dat[0].neg          = scl_dat[SCALE_CELLS].neg;
  assign scl_rdy[SCALE_CELLS]    = dab_rdy[0];

  for (genvar b = 0; b < VAL_W; b++) begin : g_dabble
    pmnf_dabble_cell u_cell (
      .clk_i       (clk_i),
      .rst_ni      (rst_ni),
      .in_valid_i  (dab_v[b]),
      .in_data_i   (dab_dat[b]),
      .in_ready_o  (dab_rdy[b]),
      .out_valid_o (dab_v[b+1]),
      .out_data_o  (dab_dat[b+1]),
      .out_ready_i (dab_rdy[b+1])
    );
  end

  pmnf_place u_place (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .mask_i        (mask),
    .len_i         (len),
    .dec_i         (dec),
    .in_valid_i    (dab_v[VAL_W]),
    .in_data_i     (dab_dat[VAL_W]),
    .in_ready_o    (dab_rdy[VAL_W]),
    .out_valid_o   (out_valid_o),
    .text_low_o    (text_low_o),
    .text_high_o   (text_high_o),
    .text_length_o (text_length_o),
    .out_stall_i   (out_stall_i)
  );

  // An empty magnitude stage always takes a transaction.
  a_take_when_empty: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !mag_v_q |-> !in_stall_o) else $error("input stalled with empty first stage");

  // The result length never exceeds the configured character count.
  a_len_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> text_length_o <= LEN_W'(MASK_CHARS)) else $error("length too large");

  // Characters beyond a short mask stay zero.
  a_high_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && text_length_o <= LEN_W'(8) |-> text_high_o == '0)
    else $error("characters beyond length not zero");

  // An empty output stage always takes a result from the end of the BCD chain.
  a_drain: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !out_valid_o |-> dab_rdy[VAL_W]) else $error("empty output stage not ready");

endmodule

/* test/picture_mask_number_formatter_tb.sv */
// Testbench of the picture mask number formatter: directed table, random masks, predictor.
`timescale 1ns / 1ps
module picture_mask_number_formatter_tb;
  import pmnf_pkg::*;

  typedef struct {
    logic [63:0] low;
    logic [63:0] high;
    logic [4:0]  len;
  } text_t;

  // One directed row: value, and optionally a literal expected text.
  typedef struct {
    logic [63:0] value;
    logic        literal;
    text_t       text;
  } row_t;

  logic             clk_i = 1'b0;
  logic             rst_ni = 1'b0;
  logic             cfg_we_i = 1'b0;
  logic [1:0]       cfg_index_i = '0;
  logic [VAL_W-1:0] cfg_data_i = '0;
  logic             in_valid_i = 1'b0;
  logic             in_stall_o;
  logic [VAL_W-1:0] value_bits_i = '0;
  logic             out_valid_o;
  logic             out_stall_i = 1'b0;
  logic [VAL_W-1:0] text_low_o;
  logic [VAL_W-1:0] text_high_o;
  logic [LEN_W-1:0] text_length_o;

  // Shadow copy of the configuration registers.
  logic [63:0] mask_lo_q, mask_hi_q;
  logic [4:0]  mask_len_q;
  logic [2:0]  kind_q;

  text_t pending_texts[$];
  int    n_errors = 0;
  bit    rx_stall_on = 1'b1;

  picture_mask_number_formatter u_top (.*);

  always #5 clk_i = ~clk_i;

  initial begin
    #20ms;
    $display("Some tests failed");
    $finish;
  end

  function automatic logic [7:0] mask_char(input int i);
    return (i < 8) ? mask_lo_q[8*i +: 8] : mask_hi_q[8*(i-8) +: 8];
  endfunction

  // Format one value against the shadow mask.
  function automatic text_t format_value(input logic [63:0] bits);
    text_t       t;
    int          len, dec, shown;
    bit          seen, neg;
    int          w;
    logic [63:0] msk, v, sbit, had;
    logic [7:0]  c, o;
    logic [7:0]  chars[16];
    len = (mask_len_q > CHARS_MAX) ? CHARS_MAX : mask_len_q;
    dec = 0; shown = 0; seen = 0; neg = 0;
    for (int i = 0; i < len; i++) begin
      c = mask_char(i);
      if (c == CH_DOT || c == CH_COMMA) seen = 1;
      else if (seen && (c == CH_HASH || c == CH_ZERO)) dec++;
    end
    w = 8 << kind_q[1:0];
    msk = (w == 64) ? '1 : ((64'd1 << w) - 1);
    v = bits & msk;
    if (kind_q[2]) begin
      sbit = 64'd1 << (w - 1);
      if (v & sbit) begin
        neg = 1;
        v = (~v + 1) & msk;
        if (v == 0) v = sbit;
      end
    end
    for (int i = 0; i < dec; i++) v = v * 10;
    for (int p = len - 1; p >= 0; p--) begin
      c = mask_char(p);
      if (c == CH_HASH || c == CH_ZERO) begin
        had = v;
        o = 8'(CH_ZERO + v % 10);
        v = v / 10;
        if (!(shown <= dec || had > 0)) o = (c == CH_ZERO) ? CH_ZERO : CH_SPACE;
        shown++;
      end else if (c == CH_MINUS || c == CH_PLUS) begin
        o = neg ? CH_MINUS : ((c == CH_PLUS) ? CH_PLUS : CH_SPACE);
      end else begin
        o = c;
      end
      chars[p] = o;
    end
    t.low = '0; t.high = '0;
    for (int i = 0; i < len; i++) begin
      if (i < 8) t.low[8*i +: 8] = chars[i];
      else t.high[8*(i-8) +: 8] = chars[i];
    end
    t.len = 5'(len);
    return t;
  endfunction

  // Mostly short gaps, a few long ones.
  function automatic int gap_len();
    int r;
    r = $urandom_range(99);
    if (r < 55) return 0;
    if (r < 92) return $urandom_range(3, 1);
    return $urandom_range(40, 8);
  endfunction

  // Write one register, then hold the port idle.
  task automatic write_reg(input cfg_reg_e idx, input logic [63:0] data);
    cfg_we_i    <= 1'b1;
    cfg_index_i <= idx;
    cfg_data_i  <= data;
    @(posedge clk_i);
    cfg_we_i <= 1'b0;
    @(posedge clk_i);
    case (idx)
      REG_MASK_LOW:  mask_lo_q  = data;
      REG_MASK_HIGH: mask_hi_q  = data;
      REG_MASK_LEN:  mask_len_q = data[4:0];
      default:       kind_q     = data[2:0];
    endcase
  endtask

  // An underscore in the string stands for a zero byte.
  task automatic set_mask(input string s, input int len, input logic [2:0] kind);
    logic [127:0] packed_mask;
    packed_mask = '0;
    for (int i = 0; i < s.len() && i < 16; i++) begin
      packed_mask[8*i +: 8] = (s[i] == "_") ? 8'h00 : s[i];
    end
    write_reg(REG_MASK_LOW, packed_mask[63:0]);
    write_reg(REG_MASK_HIGH, packed_mask[127:64]);
    write_reg(REG_MASK_LEN, 64'(len));
    write_reg(REG_KIND, 64'(kind));
  endtask

  // Drive one transaction and queue its expectation once accepted.
  task automatic send_value(input logic [63:0] v, input bit literal, input text_t t);
    int g;
    g = gap_len();
    if (g != 0) begin
      in_valid_i <= 1'b0;
      repeat (g) @(posedge clk_i);
    end
    in_valid_i   <= 1'b1;
    value_bits_i <= v;
    do @(posedge clk_i); while (in_stall_o);
    pending_texts.push_back(literal ? t : format_value(v));
  endtask

  // Drop valid, drain until nothing is expected, then let the pipeline settle.
  task automatic drain();
    in_valid_i <= 1'b0;
    while (pending_texts.size() != 0) @(posedge clk_i);
    repeat (80) @(posedge clk_i);
  endtask

  // Receiver: random stall, compare each accepted result.
  always @(posedge clk_i) begin
    text_t e;
    if (rst_ni && out_valid_o && !out_stall_i) begin
      if (pending_texts.size() == 0) begin
        $error("result with nothing expected");
        n_errors++;
      end else begin
        e = pending_texts.pop_front();
        if (text_low_o !== e.low) begin
          $error("text_low exp %h got %h", e.low, text_low_o); n_errors++;
        end
        if (text_high_o !== e.high) begin
          $error("text_high exp %h got %h", e.high, text_high_o); n_errors++;
        end
        if (text_length_o !== e.len) begin
          $error("text_length exp %0d got %0d", e.len, text_length_o); n_errors++;
        end
      end
    end
    out_stall_i <= rx_stall_on && ($urandom_range(99) < 25);
  end

  function automatic logic [7:0] rand_mask_char();
    int r;
    r = $urandom_range(99);
    if (r < 45) return ($urandom_range(1)) ? CH_HASH : CH_ZERO;
    if (r < 55) return ($urandom_range(1)) ? CH_MINUS : CH_PLUS;
    if (r < 65) return ($urandom_range(1)) ? CH_DOT : CH_COMMA;
    return 8'($urandom_range(255));
  endfunction

  function automatic logic [63:0] rand_value();
    int r;
    r = $urandom_range(9);
    if (r == 0) return 64'd0;
    if (r == 1) return '1;
    if (r == 2) return 64'd1 << $urandom_range(63);
    if (r == 3) return 64'($urandom_range(999));
    return {$urandom, $urandom};
  endfunction

  initial begin
    row_t  rows[$];
    text_t t, none;
    logic [127:0] m;
    int    items;
    mask_lo_q = '0; mask_hi_q = '0; mask_len_q = '0; kind_q = '0;
    none = '{low: '0, high: '0, len: '0};
    repeat (11) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Empty mask after reset: every field zero.
    rows = '{'{64'd0, 1'b1, none}, '{'1, 1'b1, none}};
    foreach (rows[i]) send_value(rows[i].value, rows[i].literal, rows[i].text);
    drain();

    // Signed 8-bit with sign and two decimals.
    set_mask("+##0.00", 7, 3'd4);
    t.low = 64'h0030_302E_3832_312D; // "-128.00"
    t.high = '0; t.len = 5'd7;
    rows = '{'{64'h80, 1'b1, t}, '{64'h7F, 1'b0, none}, '{64'h00, 1'b0, none},
             '{64'hFF, 1'b0, none}, '{64'h1234_5601, 1'b0, none}};
    foreach (rows[i]) send_value(rows[i].value, rows[i].literal, rows[i].text);
    drain();

    // Full-width i64, too-long length, zero byte in the mask, scale overflow.
    set_mask("-###,#0#00_##.00", 31, 3'd7);
    rows = '{'{64'h8000_0000_0000_0000, 1'b0, none}, '{'1, 1'b0, none},
             '{64'h7FFF_FFFF_FFFF_FFFF, 1'b0, none}, '{64'd0, 1'b0, none}};
    foreach (rows[i]) send_value(rows[i].value, rows[i].literal, rows[i].text);
    drain();
    for (int k = 0; k < 4; k++) begin
      set_mask("-#######0", 9, 3'(k));
      send_value('1, 1'b0, none);
      send_value(64'd5, 1'b0, none);
      drain();
      set_mask("0000+", 5, 3'(k + 4));
      send_value('1, 1'b0, none);
      send_value(64'd0, 1'b0, none);
      drain();
    end

    // Random phases: new mask each phase, including the length extremes.
    items = 0;
    while (items < 1650) begin
      for (int i = 0; i < 16; i++) m[8*i +: 8] = rand_mask_char();
      write_reg(REG_MASK_LOW, m[63:0]);
      write_reg(REG_MASK_HIGH, m[127:64]);
      case ($urandom_range(5))
        0: write_reg(REG_MASK_LEN, 64'd0);
        1: write_reg(REG_MASK_LEN, 64'($urandom_range(31, 16)));
        default: write_reg(REG_MASK_LEN, 64'($urandom_range(16, 1)));
      endcase
      write_reg(REG_KIND, 64'($urandom_range(7)));
      rx_stall_on = ($urandom_range(3) != 0);
      for (int j = 0; j < 60; j++) begin
        send_value(rand_value(), 1'b0, none);
        items++;
      end
      drain();
    end
    if (n_errors == 0 && pending_texts.size() == 0) begin
      $display("All tests passed");
    end else begin
      $display("Some tests failed");
    end
    $finish;
  end

endmodule
